[hw/rtl/lvt_pkg.sv]
// Shared types and constants for the local variance threshold block.
`default_nettype none
package lvt_pkg;

    localparam int PIX_FIELD_W    = 12;
    localparam int COL_OUT_W      = 10;
    localparam int ROW_OUT_W      = 12;
    localparam int LINE_WIDTH_W   = 11;
    localparam int LEVEL_SQ_W     = 31;
    localparam int CFG_DATA_W     = 31;
    localparam int FRAC_BITS      = 8;
    localparam int LINE_WIDTH_RST = 1024;
    localparam logic [LEVEL_SQ_W-1:0] LEVEL_SQ_RST = 31'd256;
    localparam logic [ROW_OUT_W-1:0]  ROW_MAX      = 12'd4095;

    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_LEVEL_SQ   = 1'b1
    } t_cfg_reg;

    // result fields that ride along the pipeline with each pixel
    typedef struct packed {
        logic                 emit;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
    } t_tag;

    // per-pixel control for the column sum update
    typedef struct packed {
        logic first_row;
        logic sub_old;
    } t_col_ctl;

endpackage
`default_nettype wire

[hw/rtl/lvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hw/rtl/lvt_column.sv]
// Vertical column sums: line store and column sum memories, read-modify-write per pixel.
`default_nettype none
module lvt_column #(
    parameter int WINDOW_RADIUS = 5,
    parameter int MAX_WIDTH     = 1024,
    parameter int PIXEL_BITS    = 12
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_adv,
    input  wire logic                                          i_valid,
    input  wire logic [PIXEL_BITS-1:0]                         i_px,
    input  wire logic [2*PIXEL_BITS-1:0]                       i_px_sq,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]                  i_col,
    input  wire logic [$clog2(2*WINDOW_RADIUS)-1:0]            i_slot,
    input  wire lvt_pkg::t_col_ctl                             i_ctl,
    input  wire lvt_pkg::t_tag                                 i_tag,
    output logic                                               o_valid,
    output logic [PIXEL_BITS+$clog2(2*WINDOW_RADIUS+2)-1:0]    o_cs,
    output logic [2*PIXEL_BITS+$clog2(2*WINDOW_RADIUS+2)-1:0]  o_cq,
    output lvt_pkg::t_tag                                      o_tag
);
    import lvt_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int RING = 2 * WINDOW_RADIUS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int SLW  = $clog2(RING);
    localparam int CSW  = PB + $clog2(RING + 2);
    localparam int CQW  = 2 * PB + $clog2(RING + 2);
    localparam int LAW  = SLW + CW;
    localparam int LSD  = RING * (2 ** CW);

    logic             r_b_valid;
    logic [PB-1:0]    r_b_px;
    logic [2*PB-1:0]  r_b_sq;
    logic [CW-1:0]    r_b_col;
    logic [SLW-1:0]   r_b_slot;
    t_col_ctl         r_b_ctl;
    t_tag             r_b_tag;

    logic             r_fc_we;
    logic [CW-1:0]    r_fc_addr;
    logic [CSW+CQW-1:0] r_fc_data;
    logic             r_fl_we;
    logic [LAW-1:0]   r_fl_addr;
    logic [PB-1:0]    r_fl_data;

    logic             r_c_valid;
    logic [CSW-1:0]   r_c_cs;
    logic [CQW-1:0]   r_c_cq;
    t_tag             r_c_tag;

    logic [CSW+CQW-1:0] cm_rdata;
    logic [CSW+CQW-1:0] cm_word;
    logic [PB-1:0]      ls_rdata;
    logic [PB-1:0]      old_px;
    logic [2*PB-1:0]    old_sq;
    logic [LAW-1:0]     b_laddr;
    logic [CSW-1:0]     cm_s;
    logic [CQW-1:0]     cm_q;
    logic [CSW-1:0]     cs;
    logic [CQW-1:0]     cq;
    logic [CSW-1:0]     new_s;
    logic [CQW-1:0]     new_q;
    logic               wr_en;

    assign b_laddr = {r_b_slot, r_b_col};
    assign wr_en   = i_adv & r_b_valid;

    lvt_ram #(.WIDTH(CSW + CQW), .DEPTH(2 ** CW)) u_col_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_b_col),
        .i_wdata ({new_q, new_s}),
        .i_re    (i_adv),
        .i_raddr (i_col),
        .o_rdata (cm_rdata)
    );

    lvt_ram #(.WIDTH(PB), .DEPTH(LSD)) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (b_laddr),
        .i_wdata (r_b_px),
        .i_re    (i_adv),
        .i_raddr ({i_slot, i_col}),
        .o_rdata (ls_rdata)
    );

    // forward the previous write when the same entry is read right behind it
    always_comb begin
        cm_word = (r_fc_we && r_fc_addr == r_b_col) ? r_fc_data : cm_rdata;
        old_px  = (r_fl_we && r_fl_addr == b_laddr) ? r_fl_data : ls_rdata;
        cm_s    = cm_word[CSW-1:0];
        cm_q    = cm_word[CSW+CQW-1:CSW];
        old_sq  = old_px * old_px;
        cs      = CSW'(r_b_px) + (r_b_ctl.first_row ? '0 : cm_s);
        cq      = CQW'(r_b_sq) + (r_b_ctl.first_row ? '0 : cm_q);
        new_s   = cs - (r_b_ctl.sub_old ? CSW'(old_px) : '0);
        new_q   = cq - (r_b_ctl.sub_old ? CQW'(old_sq) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_fc_we   <= 1'b0;
            r_fl_we   <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
            r_fc_we   <= r_b_valid;
            r_fl_we   <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_px    <= i_px;
            r_b_sq    <= i_px_sq;
            r_b_col   <= i_col;
            r_b_slot  <= i_slot;
            r_b_ctl   <= i_ctl;
            r_b_tag   <= i_tag;
            r_fc_addr <= r_b_col;
            r_fc_data <= {new_q, new_s};
            r_fl_addr <= b_laddr;
            r_fl_data <= r_b_px;
            r_c_cs    <= cs;
            r_c_cq    <= cq;
            r_c_tag   <= r_b_tag;
        end
    end

    assign o_valid = r_c_valid;
    assign o_cs    = r_c_cs;
    assign o_cq    = r_c_cq;
    assign o_tag   = r_c_tag;
endmodule
`default_nettype wire

[hw/rtl/lvt_window.sv]
// Horizontal window sums, variance products and the threshold compare with output register.
`default_nettype none
module lvt_window #(
    parameter int WINDOW_RADIUS = 5,
    parameter int PIXEL_BITS    = 12
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_adv,
    input  wire logic                                          i_valid,
    input  wire logic [PIXEL_BITS+$clog2(2*WINDOW_RADIUS+2)-1:0]   i_cs,
    input  wire logic [2*PIXEL_BITS+$clog2(2*WINDOW_RADIUS+2)-1:0] i_cq,
    input  wire lvt_pkg::t_tag                                 i_tag,
    input  wire logic [lvt_pkg::LEVEL_SQ_W-1:0]                i_level_sq,
    output logic                                               o_valid,
    output logic                                               o_above,
    output lvt_pkg::t_tag                                      o_tag
);
    import lvt_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int WS   = 2 * WINDOW_RADIUS + 1;
    localparam int N    = WS * WS;
    localparam int NW   = $clog2(N + 1);
    localparam int CSW  = PB + $clog2(WS + 1);
    localparam int CQW  = 2 * PB + $clog2(WS + 1);
    localparam int SW   = PB + NW;
    localparam int QW   = 2 * PB + NW;
    localparam int NQW  = QW + NW;
    localparam int LHW  = NQW + FRAC_BITS;
    localparam int RHW  = LEVEL_SQ_W + 2 * NW;
    localparam int CMPW = (LHW > RHW) ? LHW : RHW;

    logic [CSW-1:0] r_cs_line [WS];
    logic [CQW-1:0] r_cq_line [WS];
    logic [SW-1:0]  r_win_s;
    logic [QW-1:0]  r_win_q;
    logic           r_d_valid;
    t_tag           r_d_tag;
    logic           r_e_valid;
    t_tag           r_e_tag;
    logic [NQW-1:0] r_e_nq;
    logic [2*SW-1:0] r_e_s2;
    logic [RHW-1:0] r_rhs;
    logic           r_o_valid;
    logic           r_o_above;
    t_tag           r_o_tag;

    logic [NQW-1:0]  diff;
    logic [CMPW-1:0] lhs;
    logic            above;

    always_comb begin
        diff  = (r_e_nq > NQW'(r_e_s2)) ? (r_e_nq - NQW'(r_e_s2)) : '0;
        lhs   = CMPW'({diff, {FRAC_BITS{1'b0}}});
        above = lhs > CMPW'(r_rhs);
    end

    // running sums over the last WS column sums; the oldest drops out as a new one enters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WS; i++) begin
                r_cs_line[i] <= '0;
                r_cq_line[i] <= '0;
            end
            r_win_s   <= '0;
            r_win_q   <= '0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            if (i_valid) begin
                r_cs_line[0] <= i_cs;
                r_cq_line[0] <= i_cq;
                for (int i = 1; i < WS; i++) begin
                    r_cs_line[i] <= r_cs_line[i-1];
                    r_cq_line[i] <= r_cq_line[i-1];
                end
                r_win_s <= r_win_s + SW'(i_cs) - SW'(r_cs_line[WS-1]);
                r_win_q <= r_win_q + QW'(i_cq) - QW'(r_cq_line[WS-1]);
            end
            r_d_valid <= i_valid;
            r_e_valid <= r_d_valid;
            r_o_valid <= r_e_valid & r_e_tag.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rhs <= RHW'(i_level_sq) * RHW'(N * N);
        if (i_adv) begin
            r_d_tag   <= i_tag;
            r_e_tag   <= r_d_tag;
            r_e_nq    <= NQW'(r_win_q) * NQW'(N);
            r_e_s2    <= r_win_s * r_win_s;
            r_o_above <= above;
            r_o_tag   <= r_e_tag;
        end
    end

    assign o_valid = r_o_valid;
    assign o_above = r_o_above;
    assign o_tag   = r_o_tag;
endmodule
`default_nettype wire

[hw/rtl/local_variance_threshold.sv]
// An accepted pixel passes column registers b, c and window registers d, e, o to its result.
// Throughput: one pixel per cycle while the output is not stalled; each pixel does one read
// and one write on the line store and on the column sum memory, pipelined over two stages
// with forwarding. Reset clears counters, pipeline valid bits and window sums; memory
// contents stay undefined and are never used before the current frame has written them.
// No clearing pass: the block takes pixels from the first cycle after reset.
`default_nettype none
module local_variance_threshold #(
    parameter int WINDOW_RADIUS = 5,
    parameter int MAX_WIDTH     = 1024,
    parameter int PIXEL_BITS    = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [11:0] pixel
    input  wire logic        i_s_axis_tuser,   // [0] frame_start
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [0] above_level, [10:1] center_column,
                                               // [22:11] center_row
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [lvt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lvt_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int RING = 2 * WINDOW_RADIUS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int SLW  = $clog2(RING);
    localparam int WEW  = $clog2(MAX_WIDTH + 1);
    localparam int CSW  = PB + $clog2(RING + 2);
    localparam int CQW  = 2 * PB + $clog2(RING + 2);
    localparam int WRST = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;

    logic [WEW-1:0]        r_width;
    logic [LEVEL_SQ_W-1:0] r_level_sq;
    logic [CW-1:0]         r_col;
    logic [ROW_OUT_W-1:0]  r_row;
    logic [SLW-1:0]        r_slot;

    logic                  adv;
    logic                  accept;
    logic [15:0]           pix_ext;
    logic [PB-1:0]         px;
    logic [2*PB-1:0]       px_sq;
    logic [CW-1:0]         col0;
    logic [ROW_OUT_W-1:0]  row0;
    logic [SLW-1:0]        slot0;
    logic                  row_end;
    logic [LINE_WIDTH_W-1:0] cfg_w;
    t_col_ctl              ctl;
    t_tag                  tag;

    logic                  c_valid;
    logic [CSW-1:0]        c_cs;
    logic [CQW-1:0]        c_cq;
    t_tag                  c_tag;
    logic                  o_valid;
    logic                  o_above;
    t_tag                  o_tag;

    assign adv             = !o_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign accept          = i_s_axis_tvalid && adv;
    assign cfg_w           = i_cfg_wdata[LINE_WIDTH_W-1:0];

    always_comb begin
        pix_ext = {4'b0, i_s_axis_tdata[PIX_FIELD_W-1:0]};
        px      = pix_ext[PB-1:0];
        px_sq   = px * px;
        col0    = i_s_axis_tuser ? '0 : r_col;
        row0    = i_s_axis_tuser ? '0 : r_row;
        slot0   = i_s_axis_tuser ? '0 : r_slot;
        row_end = (32'(col0) + 32'd1) >= 32'(r_width);
        ctl.first_row = (row0 == '0);
        ctl.sub_old   = (row0 >= ROW_OUT_W'(RING));
        tag.emit = (row0 >= ROW_OUT_W'(RING)) && (32'(col0) >= 32'(RING));
        tag.col  = COL_OUT_W'(col0 - CW'(WINDOW_RADIUS));
        tag.row  = row0 - ROW_OUT_W'(WINDOW_RADIUS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WEW'(WRST);
            r_level_sq <= LEVEL_SQ_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: begin
                    if (32'(cfg_w) > MAX_WIDTH) begin
                        r_width <= WEW'(MAX_WIDTH);
                    end else if (cfg_w == '0) begin
                        r_width <= WEW'(1);
                    end else begin
                        r_width <= WEW'(cfg_w);
                    end
                end
                REG_LEVEL_SQ: r_level_sq <= i_cfg_wdata[LEVEL_SQ_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position of the next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col  <= '0;
                r_slot <= (slot0 == SLW'(RING - 1)) ? '0 : slot0 + SLW'(1);
                r_row  <= (row0 < ROW_MAX) ? row0 + ROW_OUT_W'(1) : row0;
            end else begin
                r_col  <= col0 + CW'(1);
                r_slot <= slot0;
                r_row  <= row0;
            end
        end
    end

    lvt_column #(
        .WINDOW_RADIUS (WINDOW_RADIUS),
        .MAX_WIDTH     (MAX_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_column (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (accept),
        .i_px    (px),
        .i_px_sq (px_sq),
        .i_col   (col0),
        .i_slot  (slot0),
        .i_ctl   (ctl),
        .i_tag   (tag),
        .o_valid (c_valid),
        .o_cs    (c_cs),
        .o_cq    (c_cq),
        .o_tag   (c_tag)
    );

    lvt_window #(
        .WINDOW_RADIUS (WINDOW_RADIUS),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (c_valid),
        .i_cs       (c_cs),
        .i_cq       (c_cq),
        .i_tag      (c_tag),
        .i_level_sq (r_level_sq),
        .o_valid    (o_valid),
        .o_above    (o_above),
        .o_tag      (o_tag)
    );

    assign o_m_axis_tvalid = o_valid;
    assign o_m_axis_tdata  = {1'b0, o_tag.row, o_tag.col, o_above};
endmodule
`default_nettype wire

[hw/rtl/lvt_checker.sv]
// Port-level checks for the local variance threshold block, bound to the top level.
`default_nettype none
module lvt_checker #(
    parameter int WINDOW_RADIUS = 5
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);
    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // input side only waits while a result is stuck
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid || i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled with free output");

    // centers in the top and left borders never appear
    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[22:11] >= 12'(WINDOW_RADIUS) &&
            o_m_axis_tdata[10:1] >= 10'(WINDOW_RADIUS))
        else $error("result for a border pixel");
endmodule

bind local_variance_threshold lvt_checker #(
    .WINDOW_RADIUS (WINDOW_RADIUS)
) u_lvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
